FILE: hdl/odo_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the odometry block.
// Used by odo_div, odo_cordic and diff_drive_odometry; depends on nothing.
package odo_pkg;

   localparam int DivW          = 64;
   localparam int DivVW         = 62;
   localparam int CordicStepsDef = 16;
   localparam int CordicMaxSteps = 24;

   localparam logic [26:0]        TwoPiQ24      = 27'd105414357;
   localparam logic [55:0]        StraightLimQ24 = 56'd1678;
   localparam logic signed [31:0] CordicGainQ30 = 32'sd652032874;
   localparam logic [63:0]        MoveLimit     = 64'h0000_0001_0000_0000;

   localparam logic CsrHalfBase   = 1'b0;
   localparam logic CsrClicksPerCm = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DL,
      ST_DC,
      ST_DTH,
      ST_MODH,
      ST_BAMH,
      ST_MODT,
      ST_BAMT,
      ST_COR1,
      ST_MUL1,
      ST_CHORD,
      ST_COR2,
      ST_MULX,
      ST_MULY,
      ST_DONE
   } odo_state_type;

   function automatic logic [31:0] atan_bam(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:    v = 32'h2000_0000;
         5'd1:    v = 32'h12E4_051E;
         5'd2:    v = 32'h09FB_385B;
         5'd3:    v = 32'h0511_11D4;
         5'd4:    v = 32'h028B_0D43;
         5'd5:    v = 32'h0145_D7E1;
         5'd6:    v = 32'h00A2_F61E;
         5'd7:    v = 32'h0051_7C55;
         5'd8:    v = 32'h0028_BE53;
         5'd9:    v = 32'h0014_5F2F;
         5'd10:   v = 32'h000A_2F98;
         5'd11:   v = 32'h0005_17CC;
         5'd12:   v = 32'h0002_8BE6;
         5'd13:   v = 32'h0001_45F3;
         5'd14:   v = 32'h0000_A2FA;
         5'd15:   v = 32'h0000_517D;
         5'd16:   v = 32'h0000_28BE;
         5'd17:   v = 32'h0000_145F;
         5'd18:   v = 32'h0000_0A30;
         5'd19:   v = 32'h0000_0518;
         5'd20:   v = 32'h0000_028C;
         5'd21:   v = 32'h0000_0146;
         5'd22:   v = 32'h0000_00A3;
         5'd23:   v = 32'h0000_0051;
         default: v = 32'h0000_0000;
      endcase
      return v;
   endfunction

endpackage

FILE: hdl/odo_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on odo_pkg for the operand widths.
module odo_div import odo_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DivW-1:0]  dividend,
   input  logic [DivVW-1:0] divisor,
   output logic             done,
   output logic [DivW-1:0]  quotient,
   output logic [DivVW-1:0] remainder
);

   localparam int CntW = $clog2(DivW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [DivW-1:0]  dq_ff, dq_in;
   logic [DivVW-1:0] rem_ff, rem_in;
   logic [DivVW-1:0] dvs_ff, dvs_in;
   logic [DivVW:0]   trial;
   logic [DivVW:0]   diff;
   logic             ge;

   assign trial = {rem_ff, dq_ff[DivW-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(DivW);
         dq_in   = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         dq_in  = {dq_ff[DivW-2:0], ge};
         rem_in = ge ? diff[DivVW-1:0] : trial[DivVW-1:0];
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = dq_ff;
   assign remainder = rem_ff;

endmodule

FILE: hdl/odo_cordic.sv
// Iterative CORDIC sine and cosine of a 32-bit binary angle, one rotation per cycle.
// Depends on odo_pkg for the gain and the arctangent table.
module odo_cordic import odo_pkg::*; #(
   parameter int CORDIC_STEPS = CordicStepsDef
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        angle,
   output logic               done,
   output logic signed [31:0] sin_out,
   output logic signed [31:0] cos_out
);

   localparam int StepW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [StepW-1:0]    step_ff, step_in;
   logic [1:0]          quad_ff, quad_in;
   logic signed [31:0]  x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [31:0]  sh_x, sh_y, atan_v;
   logic [31:0]         rot;

   assign sh_x   = x_ff >>> step_ff;
   assign sh_y   = y_ff >>> step_ff;
   assign atan_v = $signed(atan_bam(5'(step_ff)));
   assign rot    = angle + 32'h2000_0000;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quad_in = quad_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quad_in = rot[31:30];
         x_in    = CordicGainQ30;
         y_in    = '0;
         z_in    = $signed(angle - {rot[31:30], 30'b0});
      end else if (busy_ff) begin
         if (!z_ff[31]) begin
            x_in = x_ff - sh_y;
            y_in = y_ff + sh_x;
            z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + sh_y;
            y_in = y_ff - sh_x;
            z_in = z_ff + atan_v;
         end
         step_in = step_ff + StepW'(1);
         if (step_ff == StepW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quad_ff <= quad_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   always_comb begin
      case (quad_ff)
         2'd0: begin
            cos_out = x_ff;
            sin_out = y_ff;
         end
         2'd1: begin
            cos_out = -y_ff;
            sin_out = x_ff;
         end
         2'd2: begin
            cos_out = -x_ff;
            sin_out = -y_ff;
         end
         default: begin
            cos_out = y_ff;
            sin_out = -x_ff;
         end
      endcase
   end

   assign done = done_ff;

endmodule

FILE: hdl/diff_drive_odometry.sv
// Differential-drive dead-reckoning odometry: sequencer, serial multiplier and pose state.
// Depends on odo_pkg, odo_div and odo_cordic.
//
//   port group | direction | beat
//   req_       | in        | left_clicks, right_clicks (signed 16)
//   rsp_       | out       | pose_x, pose_y (signed Q8.24), pose_heading (16-bit angle)
//   csr_       | in        | wr_en, index, wdata: half base, clicks per cm
//
// A beat runs seven or eight divisions on the shared bit-serial divider, two or
// three shift-add multiplies and one or two CORDIC runs; the smaller counts are
// for a straight move and the larger ones for a turn.
// Synchronous reset clears pose to zero and loads both registers with 2560.
// req_stall is high while a beat is in flight; a finished pose waits in the output
// register under rsp_stall and the next beat is taken meanwhile.
module diff_drive_odometry import odo_pkg::*; #(
   parameter int CORDIC_STEPS = CordicStepsDef
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_left_clicks,
   input  logic signed [15:0] req_right_clicks,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pose_x,
   output logic signed [31:0] rsp_pose_y,
   output logic [15:0]        rsp_pose_heading,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata
);

   odo_state_type state_ff, state_in;
   logic          launched_ff, launched_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   half_base_ff, clicks_ff;

   logic signed [15:0] l_ff, r_ff;
   logic [31:0]        bc_ff;
   logic signed [33:0] dl_ff, dc_ff, chord_ff;
   logic [55:0]        qmag_ff;
   logic [26:0]        rsel_ff;
   logic [31:0]        bamh_ff, bamt_ff;
   logic signed [34:0] dx_ff, dy_ff;
   logic signed [31:0] pos_x_ff, pos_y_ff;
   logic [15:0]        heading_ff;

   logic [63:0] mul_acc_ff, mul_mcand_ff;
   logic [31:0] mul_mplier_ff;
   logic [5:0]  mul_cnt_ff;
   logic        mul_busy_ff, mul_done_ff, mul_neg_ff;

   logic              accept, load_pose, straight;
   logic [15:0]       b_eff, c_eff, l_mag;
   logic signed [16:0] sum_lr, diff_lr;
   logic [16:0]       sum_mag, d_mag;
   logic              d_neg;
   logic [31:0]       hb, nb, nb_rnd;

   logic              div_start, div_done;
   logic [DivW-1:0]   div_dividend, div_quo;
   logic [DivVW-1:0]  div_divisor, div_rem;
   logic              cor_start, cor_done;
   logic [31:0]       cor_angle;
   logic signed [31:0] cor_sin, cor_cos;
   logic              mul_start, mul_sign;
   logic [63:0]       mul_a;
   logic [31:0]       mul_b;

   function automatic logic signed [33:0] clamp_move(input logic neg, input logic [63:0] mag);
      logic [32:0] m;
      m = (mag > MoveLimit) ? MoveLimit[32:0] : mag[32:0];
      return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
   endfunction

   function automatic logic [26:0] wrap_turn(input logic neg, input logic [DivVW-1:0] rem);
      logic [26:0] r;
      r = rem[26:0];
      return (neg && (r != 27'd0)) ? (TwoPiQ24 - r) : r;
   endfunction

   function automatic logic [32:0] mag34(input logic signed [33:0] v);
      logic [33:0] t;
      t = v[33] ? 34'(-v) : 34'(v);
      return t[32:0];
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

   function automatic logic signed [34:0] round_q30(input logic neg, input logic [63:0] mag);
      logic signed [64:0] p;
      p = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      p = p + 65'sd536870912;
      return p[64:30];
   endfunction

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [34:0] b);
      logic signed [35:0] s;
      s = {{4{a[31]}}, a} + {b[34], b};
      if (s > 36'sd2147483647) return 32'sh7FFF_FFFF;
      if (s < -36'sd2147483648) return 32'sh8000_0000;
      return s[31:0];
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign b_eff     = (half_base_ff == 16'd0) ? 16'd1 : half_base_ff;
   assign c_eff     = (clicks_ff == 16'd0) ? 16'd1 : clicks_ff;
   assign l_mag     = l_ff[15] ? 16'(-l_ff) : 16'(l_ff);
   assign sum_lr    = {l_ff[15], l_ff} + {r_ff[15], r_ff};
   assign diff_lr   = {r_ff[15], r_ff} - {l_ff[15], l_ff};
   assign sum_mag   = sum_lr[16] ? 17'(-sum_lr) : 17'(sum_lr);
   assign d_mag     = diff_lr[16] ? 17'(-diff_lr) : 17'(diff_lr);
   assign d_neg     = diff_lr[16];
   assign straight  = (qmag_ff < StraightLimQ24);
   assign hb        = {heading_ff, 16'h0000};
   assign nb        = hb + bamt_ff;
   assign nb_rnd    = nb + 32'h0000_8000;
   assign load_pose = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   odo_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   odo_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .done    (cor_done),
      .sin_out (cor_sin),
      .cos_out (cor_cos)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_DL;
         ST_DL:    if (div_done) state_in = ST_DC;
         ST_DC:    if (div_done) state_in = ST_DTH;
         ST_DTH:   if (div_done) state_in = ST_MODH;
         ST_MODH:  if (div_done) state_in = ST_BAMH;
         ST_BAMH:  if (div_done) state_in = ST_MODT;
         ST_MODT:  if (div_done) state_in = ST_BAMT;
         ST_BAMT:  if (div_done) state_in = straight ? ST_COR2 : ST_COR1;
         ST_COR1:  if (cor_done) state_in = ST_MUL1;
         ST_MUL1:  if (mul_done_ff) state_in = ST_CHORD;
         ST_CHORD: if (div_done) state_in = ST_COR2;
         ST_COR2:  if (cor_done) state_in = ST_MULX;
         ST_MULX:  if (mul_done_ff) state_in = ST_MULY;
         ST_MULY:  if (mul_done_ff) state_in = ST_DONE;
         ST_DONE:  if (load_pose) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // unit launch and operands
   always_comb begin
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = {35'b0, TwoPiQ24};
      cor_start    = 1'b0;
      cor_angle    = bamh_ff;
      mul_start    = 1'b0;
      mul_a        = {31'b0, mag34(chord_ff)};
      mul_b        = mag32(cor_sin);
      mul_sign     = chord_ff[33] ^ cor_sin[31];
      case (state_ff)
         ST_DL: begin
            div_start    = !launched_ff;
            div_dividend = {24'b0, l_mag, 24'b0};
            div_divisor  = {46'b0, c_eff};
         end
         ST_DC: begin
            div_start    = !launched_ff;
            div_dividend = {24'b0, sum_mag, 23'b0};
            div_divisor  = {46'b0, c_eff};
         end
         ST_DTH: begin
            div_start    = !launched_ff;
            div_dividend = {8'b0, d_mag, 39'b0};
            div_divisor  = {30'b0, bc_ff};
         end
         ST_MODH: begin
            div_start    = !launched_ff;
            div_dividend = {9'b0, qmag_ff[55:1]};
         end
         ST_MODT: begin
            div_start    = !launched_ff;
            div_dividend = {8'b0, qmag_ff};
         end
         ST_BAMH, ST_BAMT: begin
            div_start    = !launched_ff;
            div_dividend = {5'b0, rsel_ff, 32'b0};
         end
         ST_COR1: begin
            cor_start = !launched_ff;
            cor_angle = bamh_ff;
         end
         ST_MUL1: begin
            mul_start = !launched_ff;
            mul_a     = {31'b0, mag34(dc_ff)};
            mul_b     = mag32(cor_sin);
            mul_sign  = dc_ff[33] ^ cor_sin[31];
         end
         ST_CHORD: begin
            div_start    = !launched_ff;
            div_dividend = mul_acc_ff;
            div_divisor  = {1'b0, qmag_ff[55:1], 6'b0};
         end
         ST_COR2: begin
            cor_start = !launched_ff;
            cor_angle = hb + bamh_ff;
         end
         ST_MULX: begin
            mul_start = !launched_ff;
            mul_b     = mag32(cor_cos);
            mul_sign  = chord_ff[33] ^ cor_cos[31];
         end
         ST_MULY: begin
            mul_start = !launched_ff;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   always_comb begin
      launched_in  = (state_in == state_ff);
      rsp_valid_in = rsp_valid_ff;
      if (load_pose) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         half_base_ff <= 16'd2560;
         clicks_ff    <= 16'd2560;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         heading_ff   <= '0;
         mul_busy_ff  <= 1'b0;
         mul_done_ff  <= 1'b0;
         mul_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CsrHalfBase:    half_base_ff <= csr_wdata;
               CsrClicksPerCm: clicks_ff    <= csr_wdata;
               default:        clicks_ff    <= clicks_ff;
            endcase
         end
         if (load_pose) begin
            pos_x_ff   <= sat_add(pos_x_ff, dx_ff);
            pos_y_ff   <= sat_add(pos_y_ff, dy_ff);
            heading_ff <= nb_rnd[31:16];
         end
         mul_done_ff <= 1'b0;
         if (mul_start) begin
            mul_busy_ff <= 1'b1;
            mul_cnt_ff  <= 6'd32;
         end else if (mul_busy_ff) begin
            mul_cnt_ff <= mul_cnt_ff - 6'd1;
            if (mul_cnt_ff == 6'd1) begin
               mul_busy_ff <= 1'b0;
               mul_done_ff <= 1'b1;
            end
         end
      end
   end

   // shift-add multiplier datapath
   always_ff @(posedge clock) begin
      if (mul_start) begin
         mul_acc_ff    <= '0;
         mul_mcand_ff  <= mul_a;
         mul_mplier_ff <= mul_b;
         mul_neg_ff    <= mul_sign;
      end else if (mul_busy_ff) begin
         if (mul_mplier_ff[0]) begin
            mul_acc_ff <= mul_acc_ff + mul_mcand_ff;
         end
         mul_mcand_ff  <= {mul_mcand_ff[62:0], 1'b0};
         mul_mplier_ff <= {1'b0, mul_mplier_ff[31:1]};
      end
   end

   // capture results of each step
   always_ff @(posedge clock) begin
      if (accept) begin
         l_ff  <= req_left_clicks;
         r_ff  <= req_right_clicks;
         bc_ff <= {16'b0, b_eff} * {16'b0, c_eff};
      end
      case (state_ff)
         ST_DL:    if (div_done) dl_ff <= clamp_move(l_ff[15], div_quo);
         ST_DC:    if (div_done) dc_ff <= clamp_move(sum_lr[16], div_quo);
         ST_DTH:   if (div_done) qmag_ff <= div_quo[55:0];
         ST_MODH:  if (div_done) rsel_ff <= wrap_turn(d_neg, div_rem);
         ST_BAMH:  if (div_done) bamh_ff <= div_quo[31:0];
         ST_MODT:  if (div_done) rsel_ff <= wrap_turn(d_neg, div_rem);
         ST_BAMT: begin
            if (div_done) begin
               bamt_ff <= div_quo[31:0];
               if (straight) begin
                  chord_ff <= dl_ff;
               end
            end
         end
         ST_CHORD: if (div_done) chord_ff <= clamp_move(mul_neg_ff ^ d_neg, div_quo);
         ST_MULX:  if (mul_done_ff) dx_ff <= round_q30(mul_neg_ff, mul_acc_ff);
         ST_MULY:  if (mul_done_ff) dy_ff <= round_q30(mul_neg_ff, mul_acc_ff);
         default:  dx_ff <= dx_ff;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pose_x       = pos_x_ff;
   assign rsp_pose_y       = pos_y_ff;
   assign rsp_pose_heading = heading_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_DL))
      else $error("accepted beat did not start the distance division");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

   a_turn_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COR1) |-> (qmag_ff >= StraightLimQ24))
      else $error("arc chord computed on a straight move");

   a_cordic_owner: assert property (@(posedge clock) disable iff (reset)
      cor_done |-> (state_ff == ST_COR1 || state_ff == ST_COR2))
      else $error("CORDIC finished outside a CORDIC step");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for diff_drive_odometry: random and directed wheel clicks,
// register changes between phases, stalls on both channels and a pose predictor.
// Depends on odo_pkg and the diff_drive_odometry RTL.
`timescale 1ns / 1ps

module testbench;
   import odo_pkg::*;

   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] right;
   } clicks_type;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [15:0]        heading;
   } pose_type;

   localparam longint TwoPi = 105414357;
   localparam longint Reach = 64'sd4294967296;
   localparam int     StallLimit = 20000;

   localparam logic [31:0] ArcTab [0:15] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_left_clicks = '0;
   logic signed [15:0] req_right_clicks = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_pose_x;
   logic signed [31:0] rsp_pose_y;
   logic [15:0]        rsp_pose_heading;
   logic               csr_wr_en = 1'b0;
   logic               csr_index = CsrHalfBase;
   logic [15:0]        csr_wdata = '0;

   clicks_type pending_clicks[$];
   pose_type   expected_poses[$];

   logic [15:0] half_base = 16'd2560;
   logic [15:0] clicks_cm = 16'd2560;
   longint      cur_x = 0;
   longint      cur_y = 0;
   logic [15:0] cur_heading = '0;

   logic        hold_sender = 1'b0;
   logic        quiet = 1'b0;
   int          mismatches = 0;
   int          beats_in = 0;
   int          beats_out = 0;
   int          idle_cycles = 0;
   int          settings_used = 1;

   diff_drive_odometry i_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint clamp_move(longint v);
      if (v > Reach) return Reach;
      if (v < -Reach) return -Reach;
      return v;
   endfunction

   function automatic longint sat_pos(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [31:0] angle_to_bam(longint rad);
      longint r;
      r = rad % TwoPi;
      if (r < 0) r += TwoPi;
      return 32'((r <<< 32) / TwoPi);
   endfunction

   function automatic void rotate_sincos(input logic [31:0] a, output longint s,
                                         output longint co);
      logic [31:0] qa;
      logic [1:0]  q;
      logic [31:0] zr;
      longint      z, x, y, nx;
      qa = a + 32'h2000_0000;
      q = qa[31:30];
      zr = a - {q, 30'b0};
      z = $signed(zr);
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'({32'b0, ArcTab[i]});
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'({32'b0, ArcTab[i]});
         end
         x = nx;
      end
      case (q)
         2'd0: begin co = x; s = y; end
         2'd1: begin co = -y; s = x; end
         2'd2: begin co = -x; s = -y; end
         default: begin co = y; s = -x; end
      endcase
   endfunction

   function automatic pose_type advance_pose(clicks_type c_in);
      longint l, r, b, c, d, dl, dc, dth, half, chord, s, co, dx, dy;
      logic [31:0] base, mid, fin;
      pose_type p;
      l = c_in.left;
      r = c_in.right;
      b = (half_base != 0) ? longint'(half_base) : 1;
      c = (clicks_cm != 0) ? longint'(clicks_cm) : 1;
      d = r - l;
      dl = clamp_move((l * 64'sd16777216) / c);
      dc = clamp_move(((l + r) * 64'sd8388608) / c);
      dth = (d * 64'sd549755813888) / (b * c);
      half = (d * 64'sd274877906944) / (b * c);
      base = {cur_heading, 16'h0};
      mid = base + angle_to_bam(half);
      fin = base + angle_to_bam(dth) + 32'h8000;
      if (dth < 1678 && dth > -1678) begin
         chord = dl;
      end else begin
         rotate_sincos(angle_to_bam(half), s, co);
         chord = clamp_move((dc * s) / (half * 64));
      end
      rotate_sincos(mid, s, co);
      dx = (chord * co + 64'sd536870912) >>> 30;
      dy = (chord * s + 64'sd536870912) >>> 30;
      cur_x = sat_pos(cur_x + dx);
      cur_y = sat_pos(cur_y + dy);
      cur_heading = fin[31:16];
      p.x = 32'(cur_x);
      p.y = 32'(cur_y);
      p.heading = cur_heading;
      return p;
   endfunction

   // driver
   always @(posedge clock) begin
      logic nv;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         nv = req_valid;
         if (req_valid && !req_stall) begin
            expected_poses.push_back(advance_pose(pending_clicks.pop_front()));
            beats_in++;
            nv = 1'b0;
         end
         if (!nv && pending_clicks.size() > 0 && !hold_sender &&
             (quiet || $urandom_range(99) >= 6)) begin
            req_left_clicks <= pending_clicks[0].left;
            req_right_clicks <= pending_clicks[0].right;
            nv = 1'b1;
         end
         req_valid <= nv;
      end
   end

   // monitor
   always @(posedge clock) begin
      pose_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            beats_out++;
            if (expected_poses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected pose beat x=%0d y=%0d h=%0d",
                           rsp_pose_x, rsp_pose_y, rsp_pose_heading);
            end else begin
               e = expected_poses.pop_front();
               if (e.x !== rsp_pose_x || e.y !== rsp_pose_y ||
                   e.heading !== rsp_pose_heading) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("pose %0d: expected x=%0d y=%0d h=%0d, got x=%0d y=%0d h=%0d",
                              beats_out, e.x, e.y, e.heading,
                              rsp_pose_x, rsp_pose_y, rsp_pose_heading);
               end
            end
         end
         rsp_stall <= !quiet && ($urandom_range(99) < 6);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("watchdog: no beat for %0d cycles", StallLimit);
         $display("** diff_drive_odometry: FAILED **");
         $finish;
      end
   end

   task automatic add_clicks(int l, int r);
      clicks_type c;
      c.left = 16'(l);
      c.right = 16'(r);
      pending_clicks.push_back(c);
   endtask

   task automatic add_random(int n);
      int l, r, mode;
      for (int i = 0; i < n; i++) begin
         mode = $urandom_range(99);
         if (mode < 60) begin
            l = $urandom_range(800) - 400;
            r = l + $urandom_range(200) - 100;
         end else if (mode < 80) begin
            l = $signed(16'($urandom));
            r = l + $urandom_range(2) - 1;
         end else begin
            l = $signed(16'($urandom));
            r = $signed(16'($urandom));
         end
         add_clicks(l, r);
      end
   endtask

   task automatic drain();
      while (pending_clicks.size() > 0 || req_valid || expected_poses.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CsrHalfBase) half_base = val;
      else clicks_cm = val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_regs(logic [15:0] b, logic [15:0] c);
      drain();
      write_reg(CsrHalfBase, b);
      write_reg(CsrClicksPerCm, c);
      settings_used++;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      add_clicks(0, 0);
      add_clicks(32767, 32767);
      add_clicks(-32768, -32768);
      add_clicks(32767, -32768);
      add_clicks(-32768, 32767);
      add_clicks(100, 100);
      add_clicks(100, 101);
      add_clicks(-1, 1);
      add_clicks(0, 2560);
      add_clicks(2560, 0);
      add_clicks(-32768, -32767);
      add_clicks(21, -21);
      add_random(140);
      drain();

      set_regs(16'd65535, 16'd65535);
      add_clicks(1, 0);
      add_clicks(0, 1);
      add_clicks(32767, 32766);
      add_clicks(-32768, 32767);
      add_random(150);

      set_regs(16'd1, 16'd1);
      add_clicks(32767, 32767);
      add_clicks(-32768, -32768);
      add_clicks(5, 5);
      add_random(120);

      set_regs(16'd0, 16'd0);
      add_clicks(1, 1);
      add_clicks(-32768, 32767);
      add_random(100);

      set_regs(16'd65535, 16'd1);
      add_random(150);

      set_regs(16'd1, 16'd65535);
      quiet = 1'b1;
      add_random(150);
      drain();
      quiet = 1'b0;

      set_regs(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)));
      add_random(150);
      while (pending_clicks.size() > 75) @(posedge clock);
      hold_sender = 1'b1;
      while (req_valid || expected_poses.size() > 0) @(posedge clock);
      hold_sender = 1'b0;

      set_regs(16'd2560, 16'd2560);
      add_random(100);
      drain();

      $display("%0d click beats sent, %0d poses checked over %0d register settings",
               beats_in, beats_out, settings_used);
      if (mismatches == 0)
         $display("** diff_drive_odometry: PASSED **");
      else
         $display("** diff_drive_odometry: FAILED **");
      $finish;
   end

endmodule
